FILE: hdl/wdl_pkg.sv
// Shared types and constants for the wall directional light level block.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package wdl_pkg;

    localparam int CRD_W       = 24;   // endpoint coordinate, Q15.8
    localparam int DIFF_W      = 25;   // endpoint difference
    localparam int AMB_W       = 5;
    localparam int DIR_W       = 16;   // light direction, Q1.14
    localparam int OFS_W       = 6;
    localparam int CFG_W       = 16;
    localparam int IDX_W       = 3;
    localparam int SQ_W        = 49;   // dx^2 + dz^2
    localparam int PROD_W      = DIR_W + DIFF_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int SQ_SHIFT    = 14;   // radicand pre-scale, gives 7 root fraction bits
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 34;
    localparam int SQ_STAGES   = 32;
    localparam int AMB_FULL    = 30;
    localparam int RECIP_30    = 1093; // ceil(2^15 / 30)
    localparam int RECIP_W     = 11;
    localparam int RECIP_SHIFT = 15;
    localparam int XW          = 10;   // integer part of a scaled offset

    localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd11585;
    localparam logic signed [DIR_W-1:0] DIR_Z_RST = 16'sd11585;
    localparam logic signed [OFS_W-1:0] MIN_RST   = -6'sd8;
    localparam logic signed [OFS_W-1:0] MAX_RST   = 6'sd8;

    typedef enum logic [IDX_W-1:0] {
        REG_DIR_X      = 3'd0,
        REG_DIR_Z      = 3'd1,
        REG_MIN_OFS    = 3'd2,
        REG_MAX_OFS    = 3'd3,
        REG_WRAP       = 3'd4,
        REG_AMB_SCALE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic                    zero;
        logic [AMB_W-1:0]        amb;
    } sq_side_t;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [AMB_W-1:0] amb;
    } div_side_t;

endpackage

FILE: hdl/wdl_front.sv
// Front stages: endpoint differences, squares and direction products, then sum and difference.
// Depends on wdl_pkg.
module wdl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [wdl_pkg::CRD_W-1:0]    start_x,
    input  logic signed [wdl_pkg::CRD_W-1:0]    start_z,
    input  logic signed [wdl_pkg::CRD_W-1:0]    end_x,
    input  logic signed [wdl_pkg::CRD_W-1:0]    end_z,
    input  logic [wdl_pkg::AMB_W-1:0]           sector_ambient,
    input  logic signed [wdl_pkg::DIR_W-1:0]    light_dir_x,
    input  logic signed [wdl_pkg::DIR_W-1:0]    light_dir_z,
    output logic                                out_valid,
    output logic [wdl_pkg::SQ_W-1:0]            sumsq,
    output wdl_pkg::sq_side_t                   side
);

    logic                                  v0_reg, v1_reg, v2_reg;
    logic signed [wdl_pkg::DIFF_W-1:0]     dx0_reg, dz0_reg, dx_next, dz_next;
    logic [wdl_pkg::AMB_W-1:0]             amb0_reg, amb1_reg;
    logic [wdl_pkg::CRD_W-1:0]             adx, adz;
    logic [2*wdl_pkg::CRD_W-1:0]           sqx1_reg, sqz1_reg, sqx_next, sqz_next;
    logic signed [wdl_pkg::PROD_W-1:0]     px1_reg, pz1_reg, px_next, pz_next;
    logic                                  zero1_reg;
    logic [wdl_pkg::SQ_W-1:0]              sumsq2_reg;
    wdl_pkg::sq_side_t                     side2_reg;

    assign dx_next = wdl_pkg::DIFF_W'(end_x) - wdl_pkg::DIFF_W'(start_x);
    assign dz_next = wdl_pkg::DIFF_W'(end_z) - wdl_pkg::DIFF_W'(start_z);

    assign adx = dx0_reg[wdl_pkg::DIFF_W-1] ? wdl_pkg::CRD_W'(-dx0_reg)
                                            : wdl_pkg::CRD_W'(dx0_reg);
    assign adz = dz0_reg[wdl_pkg::DIFF_W-1] ? wdl_pkg::CRD_W'(-dz0_reg)
                                            : wdl_pkg::CRD_W'(dz0_reg);
    assign sqx_next = adx * adx;
    assign sqz_next = adz * adz;
    assign px_next  = light_dir_z * dx0_reg;
    assign pz_next  = light_dir_x * dz0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg   <= dx_next;
            dz0_reg   <= dz_next;
            amb0_reg  <= sector_ambient;
            sqx1_reg  <= sqx_next;
            sqz1_reg  <= sqz_next;
            px1_reg   <= px_next;
            pz1_reg   <= pz_next;
            zero1_reg <= (dx0_reg == '0) && (dz0_reg == '0);
            amb1_reg  <= amb0_reg;
            sumsq2_reg     <= wdl_pkg::SQ_W'(sqx1_reg) + wdl_pkg::SQ_W'(sqz1_reg);
            side2_reg.num  <= wdl_pkg::NUM_W'(px1_reg) - wdl_pkg::NUM_W'(pz1_reg);
            side2_reg.zero <= zero1_reg;
            side2_reg.amb  <= amb1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign sumsq     = sumsq2_reg;
    assign side      = side2_reg;

endmodule

FILE: hdl/wdl_sqrt.sv
// Pipelined integer square root, one root bit per stage, of sumsq * 2^14.
// Depends on wdl_pkg.
module wdl_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [wdl_pkg::SQ_W-1:0]        sumsq,
    input  wdl_pkg::sq_side_t               in_side,
    output logic                            out_valid,
    output logic [wdl_pkg::ROOT_W-1:0]      root,
    output wdl_pkg::sq_side_t               out_side
);

    localparam int N = wdl_pkg::SQ_STAGES;

    logic                          v_reg    [N];
    logic [wdl_pkg::ROOT_W-1:0]    root_reg [N];
    logic [wdl_pkg::REM_W-1:0]     rem_reg  [N];
    logic [wdl_pkg::RAD_W-1:0]     rad_reg  [N];
    wdl_pkg::sq_side_t             side_reg [N];

    logic                          v_in     [N];
    logic [wdl_pkg::ROOT_W-1:0]    root_in  [N];
    logic [wdl_pkg::REM_W-1:0]     rem_in   [N];
    logic [wdl_pkg::RAD_W-1:0]     rad_in   [N];
    wdl_pkg::sq_side_t             side_in  [N];

    logic [wdl_pkg::REM_W-1:0]     trial    [N];
    logic [wdl_pkg::REM_W-1:0]     tsub     [N];
    logic [wdl_pkg::ROOT_W-1:0]    root_next[N];
    logic [wdl_pkg::REM_W-1:0]     rem_next [N];

    always_comb
    begin
        v_in[0]    = in_valid;
        root_in[0] = '0;
        rem_in[0]  = '0;
        rad_in[0]  = wdl_pkg::RAD_W'({sumsq, {wdl_pkg::SQ_SHIFT{1'b0}}});
        side_in[0] = in_side;
        for (int k = 1; k < N; k++)
        begin
            v_in[k]    = v_reg[k-1];
            root_in[k] = root_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            rad_in[k]  = rad_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
        // bring down two radicand bits, try root*4+1
        for (int k = 0; k < N; k++)
        begin
            trial[k] = {rem_in[k][wdl_pkg::REM_W-3:0], rad_in[k][wdl_pkg::RAD_W-1 -: 2]};
            tsub[k]  = {root_in[k], 2'b01};
            if (trial[k] >= tsub[k])
            begin
                rem_next[k]  = trial[k] - tsub[k];
                root_next[k] = {root_in[k][wdl_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial[k];
                root_next[k] = {root_in[k][wdl_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= {rad_in[k][wdl_pkg::RAD_W-3:0], 2'b00};
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

FILE: hdl/wdl_div.sv
// Pipelined restoring divider, one quotient bit per stage: |num| * 2^(FRAC_BITS-7) / root.
// Depends on wdl_pkg.
module wdl_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [wdl_pkg::ROOT_W-1:0]      divisor,
    input  wdl_pkg::sq_side_t               in_side,
    output logic                            out_valid,
    output logic [FRAC_BITS+2:0]            quot,
    output wdl_pkg::div_side_t              out_side
);

    localparam int QW  = FRAC_BITS + 3;
    localparam int PRE = FRAC_BITS - wdl_pkg::SQ_SHIFT / 2;
    localparam int DW  = wdl_pkg::NUM_W + PRE;

    logic [wdl_pkg::NUM_W-1:0]     mag;
    wdl_pkg::div_side_t            side0;

    logic                          v_reg   [QW];
    logic [DW-1:0]                 rem_reg [QW];
    logic [QW-1:0]                 q_reg   [QW];
    logic [wdl_pkg::ROOT_W-1:0]    dv_reg  [QW];
    wdl_pkg::div_side_t            side_reg[QW];

    logic                          v_in    [QW];
    logic [DW-1:0]                 rem_in  [QW];
    logic [QW-1:0]                 q_in    [QW];
    logic [wdl_pkg::ROOT_W-1:0]    dv_in   [QW];
    wdl_pkg::div_side_t            side_in [QW];

    logic [DW-1:0]                 dsh     [QW];
    logic                          ge      [QW];
    logic [DW-1:0]                 rem_next[QW];

    assign mag        = in_side.num[wdl_pkg::NUM_W-1] ? wdl_pkg::NUM_W'(-in_side.num)
                                                      : wdl_pkg::NUM_W'(in_side.num);
    assign side0.neg  = in_side.num[wdl_pkg::NUM_W-1];
    assign side0.zero = in_side.zero;
    assign side0.amb  = in_side.amb;

    always_comb
    begin
        v_in[0]    = in_valid;
        rem_in[0]  = DW'(mag) << PRE;
        q_in[0]    = '0;
        dv_in[0]   = divisor;
        side_in[0] = side0;
        for (int k = 1; k < QW; k++)
        begin
            v_in[k]    = v_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            q_in[k]    = q_reg[k-1];
            dv_in[k]   = dv_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
        // stage k decides quotient bit QW-1-k
        for (int k = 0; k < QW; k++)
        begin
            dsh[k]      = DW'(dv_in[k]) << (QW - 1 - k);
            ge[k]       = rem_in[k] >= dsh[k];
            rem_next[k] = ge[k] ? rem_in[k] - dsh[k] : rem_in[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= {q_in[k][QW-2:0], ge[k]};
                dv_reg[k]   <= dv_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

FILE: hdl/wdl_shade.sv
// Back stages: wrap and clamp, offset blend, ambient scale with divide, truncation.
// Depends on wdl_pkg.
module wdl_shade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [FRAC_BITS+2:0]                quot,
    input  wdl_pkg::div_side_t                  in_side,
    input  logic                                wrap_enable,
    input  logic                                ambient_scale_enable,
    input  logic signed [wdl_pkg::OFS_W-1:0]    min_offset,
    input  logic signed [wdl_pkg::OFS_W-1:0]    max_offset,
    output logic                                out_valid,
    output logic signed [wdl_pkg::OFS_W-1:0]    wall_light,
    output logic                                zero_length
);

    localparam int QW  = FRAC_BITS + 3;
    localparam int DPW = QW + 2;
    localparam int OW  = FRAC_BITS + 8;
    localparam int VW  = OW + wdl_pkg::OFS_W;
    localparam int PW  = FRAC_BITS + wdl_pkg::OFS_W + 1;
    localparam logic signed [DPW-1:0] ONE_S = DPW'(1) << FRAC_BITS;

    // stage 1: signed dot product, wrap, clamp
    logic signed [DPW-1:0]             dp, wt, dpw;
    logic [FRAC_BITS:0]                dpc_next, dpc1_reg;
    logic                              v1_reg, zero1_reg;
    logic [wdl_pkg::AMB_W-1:0]         amb1_reg;

    always_comb
    begin
        dp = '0;
        if (!in_side.zero)
        begin
            dp = in_side.neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        end
        wt  = dp + ONE_S;
        dpw = dp;
        if (wrap_enable)
        begin
            dpw = wt[DPW-1] ? '0 : (wt >>> 1);
        end
        if (dpw[DPW-1])
        begin
            dpc_next = '0;
        end
        else if (dpw > ONE_S)
        begin
            dpc_next = ONE_S[FRAC_BITS:0];
        end
        else
        begin
            dpc_next = dpw[FRAC_BITS:0];
        end
    end

    // stage 2: blend between the offsets
    logic signed [wdl_pkg::OFS_W-1:0]  mn;
    logic signed [wdl_pkg::OFS_W:0]    span;
    logic [PW-1:0]                     prod;
    logic signed [OW-1:0]              off_next, off2_reg;
    logic                              v2_reg, zero2_reg;
    logic [wdl_pkg::AMB_W-1:0]         amb2_reg;

    assign mn       = (min_offset > max_offset) ? max_offset : min_offset;
    assign span     = {max_offset[wdl_pkg::OFS_W-1], max_offset} - {mn[wdl_pkg::OFS_W-1], mn};
    assign prod     = dpc1_reg * span[wdl_pkg::OFS_W-1:0];
    assign off_next = (OW'(mn) <<< FRAC_BITS) + $signed({1'b0, prod});

    // stage 3: ambient scale
    logic                              sc_next, sc3_reg, v3_reg, zero3_reg;
    logic signed [VW-1:0]              val_next, val3_reg;

    assign sc_next  = ambient_scale_enable
                      && (amb2_reg < wdl_pkg::AMB_W'(wdl_pkg::AMB_FULL));
    assign val_next = sc_next ? off2_reg * $signed({1'b0, amb2_reg}) : VW'(off2_reg);

    // stage 4: divide by 30 when ambient scaled, truncate toward zero
    logic [VW-1:0]                             vmag;
    logic [wdl_pkg::XW-1:0]                    xi;
    logic [wdl_pkg::XW+wdl_pkg::RECIP_W-1:0]   rprod;
    logic [wdl_pkg::OFS_W-1:0]                 qmag;
    logic signed [wdl_pkg::OFS_W-1:0]          light_next, light4_reg;
    logic                                      v4_reg, zero4_reg;

    assign vmag  = val3_reg[VW-1] ? VW'(-val3_reg) : VW'(val3_reg);
    assign xi    = wdl_pkg::XW'(vmag >> FRAC_BITS);
    assign rprod = xi * wdl_pkg::RECIP_W'(wdl_pkg::RECIP_30);
    assign qmag  = sc3_reg ? rprod[wdl_pkg::RECIP_SHIFT +: wdl_pkg::OFS_W]
                           : xi[wdl_pkg::OFS_W-1:0];
    assign light_next = val3_reg[VW-1] ? -$signed(qmag) : $signed(qmag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpc1_reg   <= dpc_next;
            zero1_reg  <= in_side.zero;
            amb1_reg   <= in_side.amb;
            off2_reg   <= off_next;
            zero2_reg  <= zero1_reg;
            amb2_reg   <= amb1_reg;
            val3_reg   <= val_next;
            sc3_reg    <= sc_next;
            zero3_reg  <= zero2_reg;
            light4_reg <= light_next;
            zero4_reg  <= zero3_reg;
        end
    end

    assign out_valid   = v4_reg;
    assign wall_light  = light4_reg;
    assign zero_length = zero4_reg;

endmodule

FILE: hdl/wall_directional_light_level.sv
// Wall directional light level: takes one wall beat (two endpoints in Q15.8 and the
// sector ambient level) and returns the light offset of that wall under a configured
// directional light, with a flag for walls of zero length. The wall normal is
// normalized through a 32-stage square root and a (FRAC_BITS+3)-stage divider that lie
// between the front and the shade stages, and a new beat enters in every cycle unless
// the output beat is held. The whole pipeline moves as one: when the output beat is
// held by the sink, every stage holds and s_axis_tready drops in the same cycle.
// Registers are written through cfg_we/cfg_index/cfg_data and must only be changed
// while no beat is in flight; unknown indexes are dropped.
// Depends on wdl_pkg, wdl_front, wdl_sqrt, wdl_div and wdl_shade.
module wall_directional_light_level #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // start_x[23:0], start_z[47:24], end_x[71:48], end_z[95:72],
    // sector_ambient[100:96], zero pad[103:101]
    input  logic [103:0]                    s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // wall_light[5:0], zero pad[7:6]
    output logic [7:0]                      m_axis_tdata,
    // zero_length[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_we,
    input  logic [wdl_pkg::IDX_W-1:0]       cfg_index,
    input  logic [wdl_pkg::CFG_W-1:0]       cfg_data
);

    localparam int QW = FRAC_BITS + 3;

    // configuration registers
    logic signed [wdl_pkg::DIR_W-1:0]  dir_x_reg, dir_z_reg;
    logic signed [wdl_pkg::OFS_W-1:0]  min_ofs_reg, max_ofs_reg;
    logic                              wrap_reg, amb_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg     <= wdl_pkg::DIR_X_RST;
            dir_z_reg     <= wdl_pkg::DIR_Z_RST;
            min_ofs_reg   <= wdl_pkg::MIN_RST;
            max_ofs_reg   <= wdl_pkg::MAX_RST;
            wrap_reg      <= 1'b1;
            amb_scale_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (wdl_pkg::cfg_index_t'(cfg_index))
                wdl_pkg::REG_DIR_X:     dir_x_reg     <= cfg_data;
                wdl_pkg::REG_DIR_Z:     dir_z_reg     <= cfg_data;
                wdl_pkg::REG_MIN_OFS:   min_ofs_reg   <= cfg_data[wdl_pkg::OFS_W-1:0];
                wdl_pkg::REG_MAX_OFS:   max_ofs_reg   <= cfg_data[wdl_pkg::OFS_W-1:0];
                wdl_pkg::REG_WRAP:      wrap_reg      <= cfg_data[0];
                wdl_pkg::REG_AMB_SCALE: amb_scale_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // advance every stage unless the output beat is stuck
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic                              f_valid, q_valid, d_valid, o_valid;
    logic [wdl_pkg::SQ_W-1:0]          f_sumsq;
    wdl_pkg::sq_side_t                 f_side, q_side;
    logic [wdl_pkg::ROOT_W-1:0]        q_root;
    logic [QW-1:0]                     d_quot;
    wdl_pkg::div_side_t                d_side;
    logic signed [wdl_pkg::OFS_W-1:0]  o_light;
    logic                              o_zero;

    wdl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (s_axis_tvalid),
        .start_x        (s_axis_tdata[23:0]),
        .start_z        (s_axis_tdata[47:24]),
        .end_x          (s_axis_tdata[71:48]),
        .end_z          (s_axis_tdata[95:72]),
        .sector_ambient (s_axis_tdata[100:96]),
        .light_dir_x    (dir_x_reg),
        .light_dir_z    (dir_z_reg),
        .out_valid      (f_valid),
        .sumsq          (f_sumsq),
        .side           (f_side)
    );

    // length with 7 fraction bits
    wdl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .sumsq     (f_sumsq),
        .in_side   (f_side),
        .out_valid (q_valid),
        .root      (q_root),
        .out_side  (q_side)
    );

    // normalized dot product magnitude with FRAC_BITS fraction bits
    wdl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .divisor   (q_root),
        .in_side   (q_side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .out_side  (d_side)
    );

    wdl_shade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shade (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (en),
        .in_valid             (d_valid),
        .quot                 (d_quot),
        .in_side              (d_side),
        .wrap_enable          (wrap_reg),
        .ambient_scale_enable (amb_scale_reg),
        .min_offset           (min_ofs_reg),
        .max_offset           (max_ofs_reg),
        .out_valid            (o_valid),
        .wall_light           (o_light),
        .zero_length          (o_zero)
    );

    assign m_axis_tvalid = o_valid;
    assign m_axis_tdata  = {2'b00, o_light};
    assign m_axis_tuser  = o_zero;

    // a stuck output beat must hold the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output beat is stuck");

    // an empty output stage never blocks the input side
    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output stage");

    // a new output beat only shows up after the pipeline advanced
    a_output_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tready))
        else $error("output beat appeared without a pipeline advance");

endmodule
